### rtl/lru_key_value_cache_assert.svh
// Assertion macros shared by the LRU key/value cache RTL.
// Depends on nothing; included by the top level only.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LKV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lkv_pkg.sv
// Shared types and constants of the LRU key/value cache.
// Depends on nothing; used by every other RTL file but the assertion header.
package lkv_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CAP_W  = 5;
    localparam int unsigned ADDR_W = 3;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // Request kinds.
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    // Register index carried by paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_WRITE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

### rtl/lkv_if.sv
// Request and response channel interfaces of the LRU key/value cache.
// Depends on lkv_pkg for the data width.
interface lkv_req_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic signed [lkv_pkg::DATA_W-1:0] key;
    logic signed [lkv_pkg::DATA_W-1:0] value;

    modport source (output valid, kind, key, value, input ready);
    modport sink (input valid, kind, key, value, output ready);
endinterface

interface lkv_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic signed [lkv_pkg::DATA_W-1:0] read_value;

    modport source (output valid, found, read_value, input ready);
    modport sink (input valid, found, read_value, output ready);
endinterface

### rtl/lkv_ctrl.sv
// Controller state machine of the LRU key/value cache.
// Depends on lkv_pkg for the state, command and status types.
module lkv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  lkv_pkg::t_status i_status,
    output logic             o_req_ready,
    output lkv_pkg::t_cmd    o_cmd,
    output lkv_pkg::t_state  o_state
);

    lkv_pkg::t_state r_state;
    lkv_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands: take a word, search, then commit once the
    // output register is free.
    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            lkv_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lkv_pkg::S_LOOK;
                end
            end
            lkv_pkg::S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = lkv_pkg::S_WRITE;
            end
            lkv_pkg::S_WRITE: begin
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = lkv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lkv_pkg::S_IDLE;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

### rtl/lkv_dp.sv
// Datapath of the LRU key/value cache: request registers, recency-ordered
// slot array, parallel key match and output register. Depends on lkv_pkg.
module lkv_dp #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lkv_pkg::t_cmd               i_cmd,
    input  logic [lkv_pkg::CAP_W-1:0]   i_capacity,
    input  logic                        i_kind,
    input  logic [lkv_pkg::DATA_W-1:0]  i_key,
    input  logic [lkv_pkg::DATA_W-1:0]  i_value,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_found,
    output logic [lkv_pkg::DATA_W-1:0]  o_read_value,
    output lkv_pkg::t_status            o_status,
    output logic [$clog2(ENTRIES+1)-1:0] o_occupancy
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_W = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

    // Request word.
    logic                       r_kind;
    logic [lkv_pkg::DATA_W-1:0] r_key;
    logic [lkv_pkg::DATA_W-1:0] r_value;

    // Search result.
    logic             r_hit;
    logic [IDX_W-1:0] r_pos;
    logic             w_hit;
    logic [IDX_W-1:0] w_pos;

    // Slot array, slot 0 the most recent.
    logic [lkv_pkg::DATA_W-1:0] r_slot_key  [ENTRIES];
    logic [lkv_pkg::DATA_W-1:0] r_slot_data [ENTRIES];
    logic [lkv_pkg::DATA_W-1:0] n_slot_key  [ENTRIES];
    logic [lkv_pkg::DATA_W-1:0] n_slot_data [ENTRIES];
    logic [OCC_W-1:0]           r_occ;
    logic [OCC_W-1:0]           n_occ;

    // Output register.
    logic                       r_out_valid;
    logic                       r_found;
    logic [lkv_pkg::DATA_W-1:0] r_read_value;
    logic [lkv_pkg::DATA_W-1:0] w_hit_data;

    // Effective capacity, clamped to 1..ENTRIES.
    logic [CMP_W-1:0] w_cap;
    logic [CMP_W-1:0] w_occ_ext;
    logic             w_full;

    // Capture the request word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    // Compare the key with every valid slot; the lowest matching slot wins.
    always_comb begin
        w_hit = 1'b0;
        w_pos = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if ((OCC_W'(i) < r_occ) && (r_slot_key[i] == r_key)) begin
                w_hit = 1'b1;
                w_pos = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit <= w_hit;
            r_pos <= w_pos;
        end
    end

    assign w_hit_data = r_slot_data[r_pos];

    always_comb begin
        w_cap = CMP_W'(i_capacity);
        if (i_capacity == '0) begin
            w_cap = CMP_W'(1);
        end else if (CMP_W'(i_capacity) > CMP_W'(ENTRIES)) begin
            w_cap = CMP_W'(ENTRIES);
        end
        w_occ_ext = CMP_W'(r_occ);
        w_full    = (w_occ_ext >= w_cap) && (r_occ != '0);
    end

    // Slot updates: a hit moves its entry to the front, a put that misses
    // shifts everything back by one and inserts at the front.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_slot_key[i]  = r_slot_key[i];
            n_slot_data[i] = r_slot_data[i];
        end
        n_occ = r_occ;
        if (i_cmd.commit) begin
            if (r_hit) begin
                for (int i = 1; i < ENTRIES; i++) begin
                    if (IDX_W'(i) <= r_pos) begin
                        n_slot_key[i]  = r_slot_key[i-1];
                        n_slot_data[i] = r_slot_data[i-1];
                    end
                end
                n_slot_key[0]  = r_slot_key[r_pos];
                n_slot_data[0] = (r_kind == lkv_pkg::KIND_PUT) ? r_value : w_hit_data;
            end else if (r_kind == lkv_pkg::KIND_PUT) begin
                for (int i = 1; i < ENTRIES; i++) begin
                    n_slot_key[i]  = r_slot_key[i-1];
                    n_slot_data[i] = r_slot_data[i-1];
                end
                n_slot_key[0]  = r_key;
                n_slot_data[0] = r_value;
                if (!w_full) begin
                    n_occ = r_occ + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            r_slot_key[i]  <= n_slot_key[i];
            r_slot_data[i] <= n_slot_data[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // Output register; a commit is only issued while it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_found <= r_hit;
            if (r_kind == lkv_pkg::KIND_PUT) begin
                r_read_value <= r_value;
            end else if (r_hit) begin
                r_read_value <= w_hit_data;
            end else begin
                r_read_value <= lkv_pkg::MISS_VALUE;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_found           = r_found;
    assign o_read_value      = r_read_value;
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_occupancy       = r_occ;

endmodule

### rtl/lru_key_value_cache.sv
// Flow: a request word is accepted in the idle state, its key is searched in
// the look state, and the slot update and result commit follow in the write
// state once the response side is free; while the response side stalls the
// result waits in an output register. The single controller walks one
// request at a time (accept, parallel key search, slot update).
// Reset (synchronous, active low) empties the cache and sets capacity to 16.
module lru_key_value_cache #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lkv_req_if.sink                      i_req,
    lkv_rsp_if.source                    o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lkv_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

`include "lru_key_value_cache_assert.svh"

    localparam int unsigned OCC_W = $clog2(ENTRIES + 1);

    logic [lkv_pkg::CAP_W-1:0] r_capacity;
    lkv_pkg::t_cmd             w_cmd;
    lkv_pkg::t_status          w_status;
    lkv_pkg::t_state           w_state;
    logic [OCC_W-1:0]          w_occ;
    logic [lkv_pkg::DATA_W-1:0] w_read_value;

    // Configuration register, written in the APB access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkv_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == lkv_pkg::REG_CAPACITY)) begin
            r_capacity <= pwdata[lkv_pkg::CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lkv_pkg::REG_CAPACITY)
                    ? {{(32 - lkv_pkg::CAP_W){1'b0}}, r_capacity} : '0;

    // Controller.
    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (w_status),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    // Datapath.
    lkv_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_capacity   (r_capacity),
        .i_kind       (i_req.kind),
        .i_key        (i_req.key),
        .i_value      (i_req.value),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_found      (o_rsp.found),
        .o_read_value (w_read_value),
        .o_status     (w_status),
        .o_occupancy  (w_occ)
    );

    assign o_rsp.read_value = w_read_value;

    // Occupancy never passes the slot count.
    `LKV_ASSERT_IMPL(a_occ_bound, i_clk, i_rst_n, 1'b1, (w_occ <= OCC_W'(ENTRIES)), "occupancy above slot count")

    // One request at a time: after a word is taken the input stays closed.
    `LKV_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, (i_req.valid && i_req.ready), (!i_req.ready), "request taken while busy")

    // A new response only appears after a commit from the write state.
    `LKV_ASSERT_IMPL(a_rsp_from_write, i_clk, i_rst_n, $rose(o_rsp.valid), ($past(w_state) == lkv_pkg::S_WRITE), "response without commit")

    // Occupancy only grows, and by one at a time.
    `LKV_ASSERT_IMPL(a_occ_step, i_clk, i_rst_n, (w_occ != $past(w_occ)), (w_occ == $past(w_occ) + 1'b1), "occupancy jumped")

endmodule

### tb/lru_key_value_cache_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LRU key/value cache: directed and random
// get/put words, capacity changes over the register port, checked in order.
// Depends on lkv_pkg, the lkv_req_if/lkv_rsp_if interfaces and the cache RTL.

// Tracks the cache contents in recency order and the responses still owed.
class lru_scoreboard;
    localparam int unsigned ENTRIES = 16;

    typedef struct {
        logic                       found;
        logic [lkv_pkg::DATA_W-1:0] read_value;
    } t_response;

    logic [lkv_pkg::DATA_W-1:0] entry_key[ENTRIES];
    logic [lkv_pkg::DATA_W-1:0] entry_data[ENTRIES];
    int unsigned                entry_count;
    logic [lkv_pkg::CAP_W-1:0]  capacity_reg;
    t_response                  owed_responses[$];
    int                         errors;
    int                         responses_seen;

    function new();
        entry_count    = 0;
        capacity_reg   = lkv_pkg::CAP_RESET;
        errors         = 0;
        responses_seen = 0;
    endfunction

    function void set_capacity(logic [31:0] wdata);
        capacity_reg = wdata[lkv_pkg::CAP_W-1:0];
    endfunction

    // Zero acts as one and anything above the entry count saturates.
    function int unsigned effective_capacity();
        int unsigned c;
        c = capacity_reg;
        if (c < 1) c = 1;
        if (c > ENTRIES) c = ENTRIES;
        return c;
    endfunction

    // Move the entry at pos to the front, pushing the newer ones back.
    function void promote_entry(int unsigned pos);
        logic [lkv_pkg::DATA_W-1:0] k;
        logic [lkv_pkg::DATA_W-1:0] d;
        k = entry_key[pos];
        d = entry_data[pos];
        for (int unsigned i = pos; i > 0; i--) begin
            entry_key[i]  = entry_key[i-1];
            entry_data[i] = entry_data[i-1];
        end
        entry_key[0]  = k;
        entry_data[0] = d;
    endfunction

    // Apply one accepted request word and queue the response it owes.
    function void note_request(logic kind, logic [lkv_pkg::DATA_W-1:0] key,
                               logic [lkv_pkg::DATA_W-1:0] value);
        bit          hit;
        int unsigned pos;
        int unsigned fill;
        t_response   rsp;
        hit = 0;
        pos = 0;
        for (int unsigned i = 0; i < entry_count; i++) begin
            if (!hit && entry_key[i] == key) begin
                hit = 1;
                pos = i;
            end
        end
        if (kind == lkv_pkg::KIND_GET) begin
            rsp.found = hit;
            if (hit) begin
                promote_entry(pos);
                rsp.read_value = entry_data[0];
            end else begin
                rsp.read_value = lkv_pkg::MISS_VALUE;
            end
        end else begin
            if (hit) begin
                entry_data[pos] = value;
                promote_entry(pos);
            end else begin
                // Only the oldest entry goes, even if capacity dropped further.
                fill = entry_count;
                if (fill >= effective_capacity() && fill > 0) fill--;
                for (int unsigned i = fill; i > 0; i--) begin
                    entry_key[i]  = entry_key[i-1];
                    entry_data[i] = entry_data[i-1];
                end
                entry_key[0]  = key;
                entry_data[0] = value;
                entry_count   = fill + 1;
            end
            rsp.found      = hit;
            rsp.read_value = value;
        end
        owed_responses.push_back(rsp);
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Compare one accepted response word with the oldest owed response.
    task check_response(logic found, logic [lkv_pkg::DATA_W-1:0] read_value);
        t_response want;
        responses_seen++;
        if (owed_responses.size() == 0) begin
            report_mismatch($sformatf("unexpected response found=%0b value=%h",
                                      found, read_value));
        end else begin
            want = owed_responses.pop_front();
            if (found !== want.found)
                report_mismatch($sformatf("found %0b, expected %0b",
                                          found, want.found));
            if (read_value !== want.read_value)
                report_mismatch($sformatf("read_value %h, expected %h",
                                          read_value, want.read_value));
        end
    endtask
endclass

module lru_key_value_cache_test;

    localparam logic [lkv_pkg::ADDR_W-1:0] CAPACITY_ADDR = {lkv_pkg::REG_CAPACITY, 2'b00};
    localparam logic [lkv_pkg::ADDR_W-1:0] UNUSED_ADDR   = 3'b100;
    localparam logic [lkv_pkg::DATA_W-1:0] KEY_MIN       = 32'h8000_0000;
    localparam logic [lkv_pkg::DATA_W-1:0] KEY_MAX       = 32'h7FFF_FFFF;
    localparam int                         PHASE_WORDS   = 64;
    localparam int                         HOLD_AFTER    = 200;
    localparam int                         HOLD_CYCLES   = 100;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [lkv_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();

    lru_scoreboard cache_model = new();
    bit            sender_gaps;
    logic [31:0]   key_pool[$];

    lru_key_value_cache i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Give up on a hung run.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Check every response word taken by the receiver.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            cache_model.check_response(rsp_ch.found, rsp_ch.read_value);
    end

    // Receiver: switches between stall styles, with one long hold-off.
    initial begin
        int    cycle;
        int    mode;
        int    hold_left;
        bit    held;
        cycle     = 0;
        mode      = 0;
        hold_left = 0;
        held      = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (cycle % 64 == 0) mode = $urandom_range(0, 3);
            cycle++;
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (!held && cache_model.responses_seen >= HOLD_AFTER) begin
                held      = 1;
                hold_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 99) < 75);
                    2: rsp_ch.ready <= ($urandom_range(0, 99) < 40);
                    default: rsp_ch.ready <= ($urandom_range(0, 99) < 95);
                endcase
            end
        end
    end

    // Mostly back to back, sometimes a few cycles, rarely a long pause.
    function int next_gap();
        int r;
        if (!sender_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one request word and note it once the cache takes it.
    task send_word(logic kind, logic [31:0] key, logic [31:0] value);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.key   <= key;
        req_ch.value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        cache_model.note_request(kind, key, value);
    endtask

    // Let the cache drain, then write one register over the APB port.
    task write_register(logic [lkv_pkg::ADDR_W-1:0] addr, logic [31:0] data);
        req_ch.valid <= 1'b0;
        while (cache_model.owed_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == lkv_pkg::REG_CAPACITY) cache_model.set_capacity(data);
    endtask

    // Keys for one phase: a few more than fit, some of them extremes.
    task build_key_pool(int size);
        logic [31:0] extremes[4];
        extremes = '{KEY_MIN, KEY_MAX, 32'h0, 32'hFFFF_FFFF};
        key_pool.delete();
        for (int i = 0; i < size; i++) begin
            if ($urandom_range(0, 7) == 0) key_pool.push_back(extremes[$urandom_range(0, 3)]);
            else key_pool.push_back($urandom);
        end
    endtask

    task random_phase(int words);
        int          r;
        logic        kind;
        logic [31:0] key;
        logic [31:0] value;
        build_key_pool(cache_model.effective_capacity() + $urandom_range(1, 4));
        for (int i = 0; i < words; i++) begin
            r     = $urandom_range(0, 99);
            kind  = ($urandom_range(0, 1) == 1) ? lkv_pkg::KIND_PUT : lkv_pkg::KIND_GET;
            value = ($urandom_range(0, 15) == 0) ? 32'hFFFF_FFFF : $urandom;
            // A small share of words use fresh keys that rarely hit.
            if (r < 12) key = $urandom;
            else key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_word(kind, key, value);
        end
    endtask

    // Main sequence.
    initial begin
        logic [31:0] settings[7];
        int          waited;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= lkv_pkg::KIND_GET;
        req_ch.key   <= '0;
        req_ch.value <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_rst_n      <= 1'b0;
        sender_gaps  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes of keys and values, hits, misses and an update.
        send_word(lkv_pkg::KIND_GET, 32'h0, 32'h1234_5678);
        send_word(lkv_pkg::KIND_PUT, KEY_MIN, KEY_MAX);
        send_word(lkv_pkg::KIND_PUT, KEY_MAX, KEY_MIN);
        send_word(lkv_pkg::KIND_PUT, 32'h0, 32'h0);
        send_word(lkv_pkg::KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(lkv_pkg::KIND_GET, KEY_MIN, 32'hFFFF_FFFF);
        send_word(lkv_pkg::KIND_GET, 32'hFFFF_FFFF, 32'h0);
        send_word(lkv_pkg::KIND_GET, 32'h0000_3039, 32'h0);
        send_word(lkv_pkg::KIND_PUT, KEY_MAX, 32'h5);
        send_word(lkv_pkg::KIND_GET, KEY_MAX, 32'h0);

        // Capacity below occupancy: each new key drops only the oldest.
        write_register(UNUSED_ADDR, 32'h1);
        write_register(CAPACITY_ADDR, 32'h2);
        sender_gaps = 1;
        send_word(lkv_pkg::KIND_PUT, 32'h1, 32'h11);
        send_word(lkv_pkg::KIND_PUT, 32'h2, 32'h22);
        send_word(lkv_pkg::KIND_GET, KEY_MIN, 32'h0);
        send_word(lkv_pkg::KIND_GET, 32'h1, 32'h0);

        // Zero acts as one; the store stays at its occupancy.
        write_register(CAPACITY_ADDR, 32'h0);
        send_word(lkv_pkg::KIND_PUT, 32'h7, 32'h77);
        send_word(lkv_pkg::KIND_GET, 32'h2, 32'h0);
        send_word(lkv_pkg::KIND_GET, 32'h7, 32'h0);

        // Random phases across capacity settings, extremes included.
        settings = '{32'd16, 32'd1, 32'hA5A5_A5E3, 32'd31, 32'd0, 32'd8,
                     $urandom_range(0, 31)};
        for (int p = 0; p < 7; p++) begin
            write_register(CAPACITY_ADDR, settings[p]);
            sender_gaps = (p != 2);
            random_phase(PHASE_WORDS);
        end
        req_ch.valid <= 1'b0;

        // Drain the remaining responses.
        waited = 0;
        while (cache_model.owed_responses.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (cache_model.owed_responses.size() != 0)
            cache_model.report_mismatch($sformatf("%0d responses never arrived",
                                                  cache_model.owed_responses.size()));
        if (cache_model.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
